// ===== hw/rtl/sdep_rx_pkg.sv =====
`default_nettype none

package sdep_rx_pkg;

    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_HUNT_LIMIT  = 1'b1;

    localparam logic [6:0]  MAX_PAYLOAD_RST = 7'd16;
    localparam logic [15:0] HUNT_LIMIT_RST  = 16'd16000;

    // receive phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HUNT = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_IDLO = 3'd3;
    localparam logic [2:0] PH_IDHI = 3'd4;
    localparam logic [2:0] PH_LEN  = 3'd5;
    localparam logic [2:0] PH_PAY  = 3'd6;

    // result status codes
    localparam logic [2:0] ST_CONSUMED = 3'd0;
    localparam logic [2:0] ST_RESELECT = 3'd1;
    localparam logic [2:0] ST_PAYLOAD  = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_NOTREADY = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;
    localparam logic [2:0] ST_LENFAIL  = 3'd6;

    // filler and message type bytes
    localparam logic [7:0] BYTE_FILL_FF = 8'hFF;
    localparam logic [7:0] BYTE_FILL_FE = 8'hFE;
    localparam logic [7:0] TYPE_CMD     = 8'h10;
    localparam logic [7:0] TYPE_RESP    = 8'h20;
    localparam logic [7:0] TYPE_ALERT   = 8'h40;
    localparam logic [7:0] TYPE_ERROR   = 8'h80;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_RESP  = 2'd1;
    localparam logic [1:0] KIND_ALERT = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic [6:0]  max_payload;
        logic [15:0] hunt_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic [6:0]  byte_index;
        logic [1:0]  msg_kind;
        logic [15:0] msg_id;
        logic [6:0]  payload_length;
        logic        more_flag;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } type_t;

    function automatic type_t type_decode(input logic [7:0] b);
        type_t t;
        t.valid = 1'b1;
        t.kind  = KIND_CMD;
        unique case (b)
            TYPE_CMD:   t.kind = KIND_CMD;
            TYPE_RESP:  t.kind = KIND_RESP;
            TYPE_ALERT: t.kind = KIND_ALERT;
            TYPE_ERROR: t.kind = KIND_ERROR;
            default:    t.valid = 1'b0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdep_rx_if.sv =====
`default_nettype none

interface sdep_rx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       ready_line;

    modport source (output valid, output rx_byte, output ready_line, input ready);
    modport sink (input valid, input rx_byte, input ready_line, output ready);
endinterface

interface sdep_rx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [1:0]  msg_kind;
    logic [15:0] msg_id;
    logic [6:0]  payload_length;
    logic        more_flag;
    logic        last;

    modport source (
        output valid, output status, output data_byte, output byte_index,
        output msg_kind, output msg_id, output payload_length, output more_flag,
        output last, input ready
    );
    modport sink (
        input valid, input status, input data_byte, input byte_index,
        input msg_kind, input msg_id, input payload_length, input more_flag,
        input last, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sdep_rx_cfg.sv =====
`default_nettype none

module sdep_rx_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [sdep_rx_pkg::CFG_DATA_W-1:0] cfg_data,
    output sdep_rx_pkg::cfg_t                       cfg
);

    sdep_rx_pkg::cfg_t cfg_reg;
    sdep_rx_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sdep_rx_pkg::REG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data[6:0];
                sdep_rx_pkg::REG_HUNT_LIMIT:  cfg_next.hunt_limit  = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload <= sdep_rx_pkg::MAX_PAYLOAD_RST;
            cfg_reg.hunt_limit  <= sdep_rx_pkg::HUNT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sdep_rx_step.sv =====
`default_nettype none

module sdep_rx_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              ready_line,
    input  wire sdep_rx_pkg::cfg_t cfg,
    output sdep_rx_pkg::res_t      res
);

    logic [2:0]  phase_reg,         phase_next;
    logic [15:0] wait_count_reg,    wait_count_next;
    logic [1:0]  kind_reg,          kind_next;
    logic [15:0] id_reg,            id_next;
    logic [6:0]  length_reg,        length_next;
    logic        more_reg,          more_next;
    logic [6:0]  payload_count_reg, payload_count_next;

    sdep_rx_pkg::type_t tcode;
    logic [15:0] hunt_cnt;
    logic [15:0] type_cnt;
    logic [6:0]  pay_cnt;
    logic        is_fill;

    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic        last;

    assign tcode = sdep_rx_pkg::type_decode(rx_byte);
    // the count restarts from zero when a packet begins in idle
    assign hunt_cnt = ((phase_reg == sdep_rx_pkg::PH_HUNT) ? wait_count_reg : 16'd0) + 16'd1;
    assign type_cnt = wait_count_reg + 16'd1;
    assign pay_cnt  = payload_count_reg + 7'd1;
    assign is_fill  = (rx_byte == sdep_rx_pkg::BYTE_FILL_FF) ||
                      (rx_byte == sdep_rx_pkg::BYTE_FILL_FE);

    always_comb
    begin
        phase_next         = phase_reg;
        wait_count_next    = wait_count_reg;
        kind_next          = kind_reg;
        id_next            = id_reg;
        length_next        = length_reg;
        more_next          = more_reg;
        payload_count_next = payload_count_reg;
        status             = sdep_rx_pkg::ST_CONSUMED;
        data_byte          = 8'd0;
        byte_index         = 7'd0;
        last               = 1'b0;

        unique case (phase_reg)
            sdep_rx_pkg::PH_TYPE:
            begin
                if (!ready_line)
                begin
                    phase_next = sdep_rx_pkg::PH_IDLE;
                    status     = sdep_rx_pkg::ST_NOTREADY;
                end
                else
                begin
                    wait_count_next = type_cnt;
                    if (type_cnt >= cfg.hunt_limit)
                    begin
                        phase_next = sdep_rx_pkg::PH_IDLE;
                        status     = sdep_rx_pkg::ST_TIMEOUT;
                    end
                    else if (tcode.valid)
                    begin
                        kind_next  = tcode.kind;
                        phase_next = sdep_rx_pkg::PH_IDLO;
                    end
                end
            end
            sdep_rx_pkg::PH_IDLO:
            begin
                id_next[7:0] = rx_byte;
                phase_next   = sdep_rx_pkg::PH_IDHI;
            end
            sdep_rx_pkg::PH_IDHI:
            begin
                id_next[15:8] = rx_byte;
                phase_next    = sdep_rx_pkg::PH_LEN;
            end
            sdep_rx_pkg::PH_LEN:
            begin
                length_next        = rx_byte[6:0];
                more_next          = rx_byte[7];
                payload_count_next = 7'd0;
                priority if (kind_reg == sdep_rx_pkg::KIND_ERROR)
                begin
                    phase_next = sdep_rx_pkg::PH_IDLE;
                    status     = sdep_rx_pkg::ST_DONE;
                end
                else if (rx_byte[6:0] > cfg.max_payload)
                begin
                    phase_next = sdep_rx_pkg::PH_IDLE;
                    status     = sdep_rx_pkg::ST_LENFAIL;
                end
                else if (rx_byte[6:0] == 7'd0)
                begin
                    phase_next = sdep_rx_pkg::PH_IDLE;
                    status     = sdep_rx_pkg::ST_DONE;
                end
                else
                begin
                    phase_next = sdep_rx_pkg::PH_PAY;
                end
            end
            sdep_rx_pkg::PH_PAY:
            begin
                status             = sdep_rx_pkg::ST_PAYLOAD;
                data_byte          = rx_byte;
                byte_index         = payload_count_reg;
                payload_count_next = pay_cnt;
                // a wrap of the count also closes the packet
                if ((pay_cnt == length_reg) || (pay_cnt == 7'd0))
                begin
                    last       = 1'b1;
                    phase_next = sdep_rx_pkg::PH_IDLE;
                end
            end
            default:
            begin
                // idle, hunting and unused codes
                if ((phase_reg != sdep_rx_pkg::PH_HUNT) && !ready_line)
                begin
                    phase_next = sdep_rx_pkg::PH_IDLE;
                    status     = sdep_rx_pkg::ST_NOTREADY;
                end
                else
                begin
                    wait_count_next = hunt_cnt;
                    priority if (hunt_cnt >= cfg.hunt_limit)
                    begin
                        phase_next = sdep_rx_pkg::PH_IDLE;
                        status     = sdep_rx_pkg::ST_TIMEOUT;
                    end
                    else if (is_fill)
                    begin
                        phase_next = sdep_rx_pkg::PH_HUNT;
                        status     = sdep_rx_pkg::ST_RESELECT;
                    end
                    else
                    begin
                        wait_count_next = 16'd0;
                        if (tcode.valid)
                        begin
                            kind_next  = tcode.kind;
                            phase_next = sdep_rx_pkg::PH_IDLO;
                        end
                        else
                        begin
                            phase_next = sdep_rx_pkg::PH_TYPE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sdep_rx_pkg::PH_IDLE;
            wait_count_reg    <= 16'd0;
            kind_reg          <= 2'd0;
            id_reg            <= 16'd0;
            length_reg        <= 7'd0;
            more_reg          <= 1'b0;
            payload_count_reg <= 7'd0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            wait_count_reg    <= wait_count_next;
            kind_reg          <= kind_next;
            id_reg            <= id_next;
            length_reg        <= length_next;
            more_reg          <= more_next;
            payload_count_reg <= payload_count_next;
        end
    end

    always_comb
    begin
        res.status         = status;
        res.data_byte      = data_byte;
        res.byte_index     = byte_index;
        res.msg_kind       = kind_next;
        res.msg_id         = id_next;
        res.payload_length = length_next;
        res.more_flag      = more_next;
        res.last           = last;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdep_rx_out.sv =====
`default_nettype none

module sdep_rx_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire sdep_rx_pkg::res_t res,
    input  wire logic              take,
    output logic                   busy,
    output sdep_rx_pkg::res_t      res_q
);

    logic              valid_reg;
    logic              valid_next;
    sdep_rx_pkg::res_t res_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign busy  = valid_reg;
    assign res_q = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sdep_packet_receiver_core.sv =====
// a result is registered and appears on the output channel in the cycle after its request is accepted
// throughput: one request per cycle, but the input side stalls while a result waits
// and the output side is not ready; the result register refills in the cycle it is taken
// reset: asynchronous, active low; receiver back to idle, header fields zero,
// max_payload 16 and hunt_limit 16000, output register empty
`default_nettype none

module sdep_packet_receiver_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [sdep_rx_pkg::CFG_DATA_W-1:0] cfg_data,
    sdep_rx_in_if.sink                              in_ch,
    sdep_rx_out_if.source                           out_ch
);

    sdep_rx_pkg::cfg_t cfg;
    sdep_rx_pkg::res_t res;
    sdep_rx_pkg::res_t res_q;
    logic              busy;
    logic              fire;

    assign in_ch.ready = !busy || out_ch.ready;
    assign fire        = in_ch.valid && in_ch.ready;

    sdep_rx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdep_rx_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .rx_byte    (in_ch.rx_byte),
        .ready_line (in_ch.ready_line),
        .cfg        (cfg),
        .res        (res)
    );

    sdep_rx_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .res   (res),
        .take  (out_ch.ready),
        .busy  (busy),
        .res_q (res_q)
    );

    assign out_ch.valid          = busy;
    assign out_ch.status         = res_q.status;
    assign out_ch.data_byte      = res_q.data_byte;
    assign out_ch.byte_index     = res_q.byte_index;
    assign out_ch.msg_kind       = res_q.msg_kind;
    assign out_ch.msg_id         = res_q.msg_id;
    assign out_ch.payload_length = res_q.payload_length;
    assign out_ch.more_flag      = res_q.more_flag;
    assign out_ch.last           = res_q.last;

endmodule

`default_nettype wire

// ===== bench/tb_sdep_packet_receiver_core.sv =====
`timescale 1ns / 100ps

module tb_sdep_packet_receiver_core;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       ready_line;
        logic       typed;
        logic [2:0] status;
    } dir_row_t;

    localparam int N_DIR_ROWS = 26;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [sdep_rx_pkg::CFG_DATA_W-1:0] cfg_data;

    sdep_rx_in_if  in_ch ();
    sdep_rx_out_if out_ch ();

    sdep_packet_receiver_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // receiver model state
    logic [2:0]  rx_phase;
    logic [15:0] wait_cnt;
    logic [1:0]  kind_q;
    logic [15:0] id_q;
    logic [6:0]  len_q;
    logic        more_q;
    logic [6:0]  pay_cnt;
    logic [6:0]  cfg_max;
    logic [15:0] cfg_hlim;

    sdep_rx_pkg::res_t pending_results[$];
    int   err_count;
    int   items_sent;
    int   burst_left;

    // directed walk at reset settings, status typed in where obvious
    dir_row_t dir_rows [0:N_DIR_ROWS-1] = '{
        '{8'hFF, 1'b0, 1'b1, sdep_rx_pkg::ST_NOTREADY},
        '{8'h00, 1'b0, 1'b1, sdep_rx_pkg::ST_NOTREADY},
        '{8'hFF, 1'b1, 1'b1, sdep_rx_pkg::ST_RESELECT},
        '{8'hFE, 1'b0, 1'b1, sdep_rx_pkg::ST_RESELECT},
        '{8'h7F, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'hFF, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h55, 1'b0, 1'b1, sdep_rx_pkg::ST_NOTREADY},
        '{8'h10, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h00, 1'b0, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h00, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h00, 1'b0, 1'b1, sdep_rx_pkg::ST_DONE},
        '{8'hFE, 1'b1, 1'b1, sdep_rx_pkg::ST_RESELECT},
        '{8'h20, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'hFF, 1'b0, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'hFF, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h82, 1'b0, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h00, 1'b0, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'hFF, 1'b1, 1'b1, sdep_rx_pkg::ST_PAYLOAD},
        '{8'h40, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h34, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h12, 1'b0, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h11, 1'b1, 1'b1, sdep_rx_pkg::ST_LENFAIL},
        '{8'h80, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h01, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'h80, 1'b1, 1'b0, sdep_rx_pkg::ST_CONSUMED},
        '{8'hFF, 1'b1, 1'b1, sdep_rx_pkg::ST_DONE}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[sdep_packet_receiver_core] ERROR");
        $finish;
    end

    function automatic void accept_type(input logic [7:0] b);
        rx_phase = sdep_rx_pkg::PH_IDLO;
        case (b)
            sdep_rx_pkg::TYPE_CMD:   kind_q = sdep_rx_pkg::KIND_CMD;
            sdep_rx_pkg::TYPE_RESP:  kind_q = sdep_rx_pkg::KIND_RESP;
            sdep_rx_pkg::TYPE_ALERT: kind_q = sdep_rx_pkg::KIND_ALERT;
            sdep_rx_pkg::TYPE_ERROR: kind_q = sdep_rx_pkg::KIND_ERROR;
            default:                 rx_phase = sdep_rx_pkg::PH_TYPE;
        endcase
    endfunction

    function automatic logic [2:0] hunt_poll(input logic [7:0] b);
        wait_cnt = wait_cnt + 16'd1;
        if (wait_cnt >= cfg_hlim)
        begin
            rx_phase = sdep_rx_pkg::PH_IDLE;
            return sdep_rx_pkg::ST_TIMEOUT;
        end
        if (b == sdep_rx_pkg::BYTE_FILL_FF || b == sdep_rx_pkg::BYTE_FILL_FE)
        begin
            rx_phase = sdep_rx_pkg::PH_HUNT;
            return sdep_rx_pkg::ST_RESELECT;
        end
        wait_cnt = '0;
        accept_type(b);
        return sdep_rx_pkg::ST_CONSUMED;
    endfunction

    function automatic sdep_rx_pkg::res_t next_result(input logic [7:0] b, input logic rdy);
        sdep_rx_pkg::res_t r;
        r = '0;
        r.status = sdep_rx_pkg::ST_CONSUMED;
        case (rx_phase)
            sdep_rx_pkg::PH_HUNT: r.status = hunt_poll(b);
            sdep_rx_pkg::PH_TYPE:
            begin
                if (!rdy)
                begin
                    rx_phase = sdep_rx_pkg::PH_IDLE;
                    r.status = sdep_rx_pkg::ST_NOTREADY;
                end
                else
                begin
                    wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= cfg_hlim)
                    begin
                        rx_phase = sdep_rx_pkg::PH_IDLE;
                        r.status = sdep_rx_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        accept_type(b);
                    end
                end
            end
            sdep_rx_pkg::PH_IDLO:
            begin
                id_q[7:0] = b;
                rx_phase = sdep_rx_pkg::PH_IDHI;
            end
            sdep_rx_pkg::PH_IDHI:
            begin
                id_q[15:8] = b;
                rx_phase = sdep_rx_pkg::PH_LEN;
            end
            sdep_rx_pkg::PH_LEN:
            begin
                len_q = b[6:0];
                more_q = b[7];
                pay_cnt = '0;
                rx_phase = sdep_rx_pkg::PH_IDLE;
                if (kind_q == sdep_rx_pkg::KIND_ERROR)
                    r.status = sdep_rx_pkg::ST_DONE;
                else if (len_q > cfg_max)
                    r.status = sdep_rx_pkg::ST_LENFAIL;
                else if (len_q == 7'd0)
                    r.status = sdep_rx_pkg::ST_DONE;
                else
                    rx_phase = sdep_rx_pkg::PH_PAY;
            end
            sdep_rx_pkg::PH_PAY:
            begin
                r.status = sdep_rx_pkg::ST_PAYLOAD;
                r.data_byte = b;
                r.byte_index = pay_cnt;
                pay_cnt = pay_cnt + 7'd1;
                if (pay_cnt == len_q || pay_cnt == 7'd0)
                begin
                    r.last = 1'b1;
                    rx_phase = sdep_rx_pkg::PH_IDLE;
                end
            end
            default:
            begin
                if (!rdy)
                begin
                    rx_phase = sdep_rx_pkg::PH_IDLE;
                    r.status = sdep_rx_pkg::ST_NOTREADY;
                end
                else
                begin
                    wait_cnt = '0;
                    r.status = hunt_poll(b);
                end
            end
        endcase
        r.msg_kind = kind_q;
        r.msg_id = id_q;
        r.payload_length = len_q;
        r.more_flag = more_q;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        if (err_count <= 200)
            $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
    endtask

    task automatic check_result(input sdep_rx_pkg::res_t got);
        sdep_rx_pkg::res_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, status", got.status, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", got.byte_index, want.byte_index);
        if (got.msg_kind !== want.msg_kind)
            report_mismatch("msg_kind", got.msg_kind, want.msg_kind);
        if (got.msg_id !== want.msg_id)
            report_mismatch("msg_id", got.msg_id, want.msg_id);
        if (got.payload_length !== want.payload_length)
            report_mismatch("payload_length", got.payload_length, want.payload_length);
        if (got.more_flag !== want.more_flag)
            report_mismatch("more_flag", got.more_flag, want.more_flag);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge clk)
    begin
        sdep_rx_pkg::res_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.status = out_ch.status;
            got.data_byte = out_ch.data_byte;
            got.byte_index = out_ch.byte_index;
            got.msg_kind = out_ch.msg_kind;
            got.msg_id = out_ch.msg_id;
            got.payload_length = out_ch.payload_length;
            got.more_flag = out_ch.more_flag;
            got.last = out_ch.last;
            check_result(got);
        end
    end

    // receiver stall pattern; the mode is picked at random from four
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 300 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ((cyc % 7) < 4);
                default: out_ch.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    task automatic push_request(input logic [7:0] b, input logic rdy, input logic typed,
                                input logic [2:0] st);
        sdep_rx_pkg::res_t want;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        want = next_result(b, rdy);
        if (typed)
            want.status = st;
        pending_results.push_back(want);
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.ready_line <= rdy;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic rdy);
        push_request(b, rdy, 1'b0, sdep_rx_pkg::ST_CONSUMED);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [sdep_rx_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sdep_rx_pkg::REG_MAX_PAYLOAD)
            cfg_max = val[6:0];
        else
            cfg_hlim = val;
    endtask

    task automatic send_packet();
        int n;
        int len;
        int sel;
        logic [7:0] t;
        logic [7:0] junk;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_byte($urandom_range(0, 1) ? sdep_rx_pkg::BYTE_FILL_FF
                                           : sdep_rx_pkg::BYTE_FILL_FE,
                      (i == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
        // bytes that are neither filler nor type park the receiver in the type phase
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                junk = 8'($urandom_range(0, 255)) & 8'h7F;
                if (junk == sdep_rx_pkg::TYPE_CMD || junk == sdep_rx_pkg::TYPE_RESP ||
                    junk == sdep_rx_pkg::TYPE_ALERT)
                    junk = junk ^ 8'h01;
                send_byte(junk, ($urandom_range(0, 9) != 0));
            end
        end
        case ($urandom_range(0, 3))
            0:       t = sdep_rx_pkg::TYPE_CMD;
            1:       t = sdep_rx_pkg::TYPE_RESP;
            2:       t = sdep_rx_pkg::TYPE_ALERT;
            default: t = sdep_rx_pkg::TYPE_ERROR;
        endcase
        send_byte(t, ($urandom_range(0, 9) != 0));
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sel = $urandom_range(0, 9);
        if (sel == 0)
            len = 0;
        else if (sel == 1 && cfg_max < 7'd127)
            len = $urandom_range(cfg_max + 1, 127);
        else if (sel == 2)
            len = cfg_max;
        else if (cfg_max == 7'd0)
            len = 0;
        else
            len = $urandom_range(1, (cfg_max < 7'd6) ? cfg_max : 6);
        send_byte({1'($urandom_range(0, 1)), 7'(len)}, 1'($urandom_range(0, 1)));
        if (t != sdep_rx_pkg::TYPE_ERROR && len != 0 && len <= cfg_max)
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(input int budget);
        int start;
        bit paused;
        start = items_sent;
        paused = 1'b0;
        while (items_sent - start < budget)
        begin
            if (!paused && items_sent - start >= budget / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_packet();
            end
        end
    endtask

    task automatic run_setting(input logic [6:0] mx, input logic [15:0] hl, input int budget);
        drain_results();
        write_reg(sdep_rx_pkg::REG_MAX_PAYLOAD, {{(sdep_rx_pkg::CFG_DATA_W-7){1'b0}}, mx});
        write_reg(sdep_rx_pkg::REG_HUNT_LIMIT, hl);
        run_random(budget);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= '0;
        in_ch.ready_line <= 1'b0;
        err_count = 0;
        items_sent = 0;
        burst_left = 0;
        rx_phase = sdep_rx_pkg::PH_IDLE;
        wait_cnt = '0;
        kind_q = sdep_rx_pkg::KIND_CMD;
        id_q = '0;
        len_q = '0;
        more_q = 1'b0;
        pay_cnt = '0;
        cfg_max = sdep_rx_pkg::MAX_PAYLOAD_RST;
        cfg_hlim = sdep_rx_pkg::HUNT_LIMIT_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR_ROWS; i++)
            push_request(dir_rows[i].rx_byte, dir_rows[i].ready_line, dir_rows[i].typed,
                         dir_rows[i].status);
        run_random(150);

        run_setting(7'd0, 16'd1, 200);
        run_setting(7'd127, 16'd65535, 200);
        run_setting(7'd127, 16'd2, 200);
        run_setting(7'($urandom_range(0, 127)), 16'($urandom_range(3, 12)), 200);
        run_setting(7'd5, 16'd16000, 200);
        run_setting(7'($urandom_range(0, 127)), 16'($urandom_range(1, 65535)), 200);

        drain_results();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("[sdep_packet_receiver_core] OK");
        else
            $display("[sdep_packet_receiver_core] ERROR");
        $finish;
    end

endmodule

// ===== sdep_packet_receiver_core.f =====
hw/rtl/sdep_rx_pkg.sv
hw/rtl/sdep_rx_if.sv
hw/rtl/sdep_rx_cfg.sv
hw/rtl/sdep_rx_step.sv
hw/rtl/sdep_rx_out.sv
hw/rtl/sdep_packet_receiver_core.sv
bench/tb_sdep_packet_receiver_core.sv
